// ===== design/frame_animation_sequencer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// frame animation sequencer assertion macros
// shared assertion shorthands for the sequencer rtl
// ----------------------------------------------------------------------------
`ifndef FRAME_ANIMATION_SEQUENCER_UNIT_MACROS_SVH
`define FRAME_ANIMATION_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define FAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fas_pkg.sv =====
// ----------------------------------------------------------------------------
// frame animation sequencer package
// item types, codes and table sizes shared by the sequencer rtl
// ----------------------------------------------------------------------------
`default_nettype none

package fas_pkg;

    localparam int NUM_SEQUENCES  = 8;
    localparam int SEQUENCE_DEPTH = 16;
    localparam int SEQ_W          = 3;
    localparam int POS_W          = 4;
    localparam int ADDR_W         = SEQ_W + POS_W;
    localparam int TABLE_SIZE     = NUM_SEQUENCES * SEQUENCE_DEPTH;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_WRITE     = 3'd1,
        ACT_SELECT    = 3'd2,
        ACT_SET_POS   = 3'd3,
        ACT_SET_FRAME = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_SINGLE   = 2'd1,
        MODE_COUNTED  = 2'd2,
        MODE_SEQUENCE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_RUNNING   = 2'd0,
        ST_DONE      = 2'd1,
        ST_RESTARTED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_MODE        = 2'd0,
        CFG_ONE_SHOT    = 2'd1,
        CFG_SPEED       = 2'd2,
        CFG_FRAME_COUNT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]       action;
        logic [SEQ_W-1:0] sequence_number;
        logic [POS_W-1:0] position;
        logic [7:0]       entry_value;
        logic             entry_is_end;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0]       frame;
        logic [POS_W-1:0] frame_position;
        logic [1:0]       status;
    } rsp_item_t;

    typedef struct packed {
        logic       is_end;
        logic [7:0] value;
    } entry_t;

endpackage

`default_nettype wire

// ===== design/frame_animation_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// frame animation sequencer unit
// sprite frame sequencer: prescaled ticks step a counted frame or a stored
// sequence of frames; commands load the sequence table and set position/frame
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_animation_sequencer_unit_macros.svh"

// One cmd item is taken per clock while the rsp side keeps up, and gives
// exactly one rsp item. rsp_valid rises once the item has passed the execute
// register and the rsp register. At acceptance the item is captured into the
// execute register while the sequence table is written (write entry) or read
// on two ports at the addresses the item will need, with the read data
// registered. When the rsp register is free, the execute logic updates frame,
// position, prescaler and status and loads the rsp register. While rsp_ready
// holds, the sustained rate is one item per cycle, set by that memory read
// register plus the single execute register. The table has a valid bit per
// entry, so it reads as end marks right after reset with no clearing pass;
// the block is ready immediately. Configuration is written through cfg_write /
// cfg_index / cfg_data and must only change while no item is in flight.
module frame_animation_sequencer_unit (
    input  wire               clk,
    input  wire               rst_n,
    // command channel
    input  wire               cmd_valid,
    output logic              cmd_ready,
    input  wire fas_pkg::cmd_item_t cmd,
    // result channel
    output logic              rsp_valid,
    input  wire               rsp_ready,
    output fas_pkg::rsp_item_t rsp,
    // configuration write port
    input  wire               cfg_write,
    input  wire [1:0]         cfg_index,
    input  wire [15:0]        cfg_data
);
    import fas_pkg::*;

    // configuration registers
    logic [1:0]       mode_reg;
    logic             one_shot_reg;
    logic [15:0]      speed_reg;
    logic [8:0]       frame_count_reg;

    // animation state
    logic [15:0]      tick_count_reg, tick_count_next;
    logic [7:0]       frame_reg, frame_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic [SEQ_W-1:0] sel_reg, sel_next;
    logic [1:0]       status_reg, status_next;

    // execute stage and result register
    logic             ex_valid_reg;
    cmd_item_t        ex_item_reg;
    logic             ex_fire;
    logic             cmd_accept;
    logic             rsp_valid_reg;
    rsp_item_t        rsp_reg;

    // sequence table with per-entry valid bits
    entry_t                  table_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0]   entry_valid_reg;
    entry_t                  rd0_data_reg, rd1_data_reg;
    logic                    rd0_live_reg, rd1_live_reg;
    logic [ADDR_W-1:0]       rd0_addr, rd1_addr, wr_addr;
    logic                    rd0_past_end;
    logic                    wr_en;
    logic [POS_W:0]          pos_inc;
    logic [POS_W-1:0]        pos_sat;
    logic                    e0_end, e1_end;

    // handshake: execute stage drains whenever the rsp register is free
    assign ex_fire    = ex_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready  = !ex_valid_reg || ex_fire;
    assign cmd_accept = cmd_valid && cmd_ready;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_SINGLE;
            one_shot_reg    <= 1'b0;
            speed_reg       <= 16'd1;
            frame_count_reg <= 9'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODE:        mode_reg        <= cfg_data[1:0];
                CFG_ONE_SHOT:    one_shot_reg    <= cfg_data[0];
                CFG_SPEED:       speed_reg       <= cfg_data;
                CFG_FRAME_COUNT: frame_count_reg <= cfg_data[8:0];
                default:         ;
            endcase
        end
    end

    // table entries are ended by the valid bit or by their own end flag
    assign e0_end = !rd0_live_reg || rd0_data_reg.is_end;
    assign e1_end = !rd1_live_reg || rd1_data_reg.is_end;

    // position saturates at the last table slot
    function automatic logic [POS_W-1:0] pos_sat_f(input logic [POS_W-1:0] p);
        logic [POS_W:0] wide;
        wide = {1'b0, p};
        if (wide > (POS_W+1)'(SEQUENCE_DEPTH - 1))
            return POS_W'(SEQUENCE_DEPTH - 1);
        return p;
    endfunction

    // execute: next state for the item in the execute register
    always_comb
    begin
        logic [15:0] limit;
        logic [16:0] tick_inc;
        logic        fires;
        logic [8:0]  frame_inc;

        tick_count_next = tick_count_reg;
        frame_next      = frame_reg;
        position_next   = position_reg;
        sel_next        = sel_reg;
        status_next     = status_reg;

        limit     = (speed_reg == 16'd0) ? 16'd1 : speed_reg;
        tick_inc  = {1'b0, tick_count_reg} + 17'd1;
        fires     = (tick_inc >= {1'b0, limit});
        frame_inc = {1'b0, frame_reg} + 9'd1;

        if (ex_fire)
        begin
            case (ex_item_reg.action)
                ACT_TICK:
                begin
                    status_next = ST_RUNNING;
                    case (mode_reg)
                        MODE_SINGLE:
                        begin
                            frame_next  = 8'd0;
                            status_next = ST_DONE;
                        end
                        MODE_COUNTED:
                        begin
                            tick_count_next = fires ? 16'd0 : tick_inc[15:0];
                            if (fires)
                            begin
                                // wrap at frame_count or past the 8-bit range
                                if (frame_inc >= frame_count_reg || frame_inc > 9'd255)
                                begin
                                    frame_next  = 8'd0;
                                    status_next = ST_RESTARTED;
                                end
                                else
                                begin
                                    frame_next = frame_inc[7:0];
                                end
                            end
                        end
                        MODE_SEQUENCE:
                        begin
                            tick_count_next = fires ? 16'd0 : tick_inc[15:0];
                            if (fires)
                            begin
                                if (!e0_end)
                                begin
                                    position_next = position_reg + POS_W'(1);
                                    frame_next    = rd0_data_reg.value;
                                end
                                else
                                begin
                                    // port 1 holds current entry (one-shot) or entry 0
                                    status_next = one_shot_reg ? ST_DONE : ST_RESTARTED;
                                    if (!one_shot_reg)
                                        position_next = '0;
                                    if (!e1_end)
                                        frame_next = rd1_data_reg.value;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                ACT_SELECT:
                begin
                    if ({1'b0, ex_item_reg.sequence_number} < (SEQ_W+1)'(NUM_SEQUENCES))
                    begin
                        sel_next      = ex_item_reg.sequence_number;
                        position_next = '0;
                        if (mode_reg == MODE_SEQUENCE && !e0_end)
                            frame_next = rd0_data_reg.value;
                    end
                end
                ACT_SET_POS:
                begin
                    if (mode_reg == MODE_SEQUENCE || one_shot_reg)
                    begin
                        position_next = pos_sat_f(ex_item_reg.position);
                        if (!e0_end)
                            frame_next = rd0_data_reg.value;
                    end
                end
                ACT_SET_FRAME:
                begin
                    if ({1'b0, ex_item_reg.entry_value} < frame_count_reg)
                        frame_next = ex_item_reg.entry_value;
                end
                default: ;
            endcase
        end
    end

    // table addresses for the incoming item, against the state it will see
    always_comb
    begin
        pos_inc      = {1'b0, position_next} + (POS_W+1)'(1);
        pos_sat      = pos_sat_f(cmd.position);
        rd0_past_end = 1'b0;
        rd0_addr     = {sel_next, pos_inc[POS_W-1:0]};
        rd1_addr     = {sel_next, (one_shot_reg ? position_next : {POS_W{1'b0}})};
        case (cmd.action)
            ACT_TICK:
            begin
                // a step past the last slot reads as an end mark
                rd0_past_end = (pos_inc >= (POS_W+1)'(SEQUENCE_DEPTH));
            end
            ACT_SELECT:  rd0_addr = {cmd.sequence_number, {POS_W{1'b0}}};
            ACT_SET_POS: rd0_addr = {sel_next, pos_sat};
            default:     ;
        endcase
        wr_addr = {cmd.sequence_number, cmd.position};
        wr_en   = cmd_accept && (cmd.action == ACT_WRITE)
               && ({1'b0, cmd.sequence_number} < (SEQ_W+1)'(NUM_SEQUENCES))
               && ({1'b0, cmd.position} < (POS_W+1)'(SEQUENCE_DEPTH));
    end

    // table memory: a write for a write item and two registered reads per accepted item
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_addr] <= '{is_end: cmd.entry_is_end, value: cmd.entry_value};
        if (cmd_accept)
        begin
            rd0_data_reg <= table_mem[rd0_addr];
            rd1_data_reg <= table_mem[rd1_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd0_live_reg    <= 1'b0;
            rd1_live_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
                entry_valid_reg[wr_addr] <= 1'b1;
            if (cmd_accept)
            begin
                rd0_live_reg <= entry_valid_reg[rd0_addr] && !rd0_past_end;
                rd1_live_reg <= entry_valid_reg[rd1_addr];
            end
        end
    end

    // state, execute stage and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            frame_reg      <= '0;
            position_reg   <= '0;
            sel_reg        <= '0;
            status_reg     <= ST_DONE;
            ex_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            frame_reg      <= frame_next;
            position_reg   <= position_next;
            sel_reg        <= sel_next;
            status_reg     <= status_next;
            if (cmd_accept)
                ex_valid_reg <= 1'b1;
            else if (ex_fire)
                ex_valid_reg <= 1'b0;
            if (ex_fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
            ex_item_reg <= cmd;
        if (ex_fire)
        begin
            rsp_reg.frame          <= frame_next;
            rsp_reg.frame_position <= position_next;
            rsp_reg.status         <= status_next;
        end
    end

    // checks
    `FAS_ASSERT_NEXT(a_ex_hold, clk, rst_n, ex_valid_reg && !ex_fire,
        ex_valid_reg && $stable(ex_item_reg), "stalled execute item changed")
    `FAS_ASSERT_NEXT(a_accept_to_ex, clk, rst_n, cmd_accept,
        ex_valid_reg, "accepted item missing from execute stage")
    `FAS_ASSERT_NEXT(a_fire_to_rsp, clk, rst_n, ex_fire,
        rsp_valid_reg, "executed item produced no result")
    `FAS_ASSERT_NEXT(a_frame_quiet, clk, rst_n, !ex_fire,
        $stable(frame_reg) && $stable(position_reg), "state moved with no item")

endmodule

`default_nettype wire

// ===== tb/sv/fas_frame_checker.sv =====
// ----------------------------------------------------------------------------
// frame animation sequencer checker
// watches the command, result and register ports, predicts every result
// from its own copy of the sequencer state and compares in order
// ----------------------------------------------------------------------------
module fas_frame_checker (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cmd_valid,
    input  wire                cmd_ready,
    input  fas_pkg::cmd_item_t cmd,
    input  wire                rsp_valid,
    input  wire                rsp_ready,
    input  fas_pkg::rsp_item_t rsp,
    input  wire                cfg_write,
    input  wire [1:0]          cfg_index,
    input  wire [15:0]         cfg_data,
    output int unsigned        mismatches,
    output int unsigned        awaiting,
    output int unsigned        commands_seen,
    output int unsigned        results_seen
);
    import fas_pkg::*;

    localparam int unsigned MAX_REPORTS = 40;

    // register copies
    mode_t       cfg_mode;
    logic        cfg_one_shot;
    logic [15:0] cfg_speed;
    logic [8:0]  cfg_frames;

    // sequencer state copies
    logic [15:0]      tick_cnt;
    logic [7:0]       cur_frame;
    logic [POS_W-1:0] cur_pos;
    logic [SEQ_W-1:0] sel_seq;
    entry_t           seq_store [TABLE_SIZE];
    status_t          last_st;

    rsp_item_t   expected_frames_q [$];
    rsp_item_t   want_rsp;
    rsp_item_t   predicted;
    int unsigned fail_total;
    int unsigned cmd_total;
    int unsigned rsp_total;

    function automatic void reset_animation();
        cfg_mode     = MODE_SINGLE;
        cfg_one_shot = 1'b0;
        cfg_speed    = 16'd1;
        cfg_frames   = '0;
        tick_cnt     = '0;
        cur_frame    = '0;
        cur_pos      = '0;
        sel_seq      = '0;
        last_st      = ST_DONE;
        foreach (seq_store[i])
            seq_store[i] = '{is_end: 1'b1, value: 8'd0};
        expected_frames_q.delete();
    endfunction

    function automatic void apply_register(logic [1:0] idx, logic [15:0] d);
        case (cfg_reg_t'(idx))
            CFG_MODE:        cfg_mode = mode_t'(d[1:0]);
            CFG_ONE_SHOT:    cfg_one_shot = d[0];
            CFG_SPEED:       cfg_speed = d;
            CFG_FRAME_COUNT: cfg_frames = d[8:0];
            default: ;
        endcase
    endfunction

    // anything outside the table reads as an end mark
    function automatic entry_t stored_entry(int unsigned s, int unsigned p);
        entry_t e;
        e = '{is_end: 1'b1, value: 8'd0};
        if (s < NUM_SEQUENCES && p < SEQUENCE_DEPTH)
            e = seq_store[s * SEQUENCE_DEPTH + p];
        return e;
    endfunction

    // an end mark never replaces the shown frame
    function automatic void load_from(int unsigned p);
        entry_t e;
        e = stored_entry(sel_seq, p);
        if (!e.is_end)
            cur_frame = e.value;
    endfunction

    function automatic bit prescaler_wraps();
        int unsigned lim;
        int unsigned nxt;
        lim = (cfg_speed == 0) ? 1 : cfg_speed;
        nxt = tick_cnt + 1;
        if (nxt >= lim) begin
            tick_cnt = '0;
            return 1'b1;
        end
        tick_cnt = 16'(nxt);
        return 1'b0;
    endfunction

    function automatic status_t frame_step();
        status_t     st;
        int unsigned nxt;
        entry_t      e;
        st = ST_RUNNING;
        case (cfg_mode)
            MODE_SINGLE:
            begin
                cur_frame = '0;
                st = ST_DONE;
            end
            MODE_COUNTED:
            begin
                if (prescaler_wraps()) begin
                    nxt = cur_frame + 1;
                    if (nxt >= cfg_frames || nxt > 255) begin
                        cur_frame = '0;
                        st = ST_RESTARTED;
                    end
                    else begin
                        cur_frame = 8'(nxt);
                    end
                end
            end
            MODE_SEQUENCE:
            begin
                if (prescaler_wraps()) begin
                    nxt = cur_pos + 1;
                    e = stored_entry(sel_seq, nxt);
                    if (!e.is_end) begin
                        cur_pos = POS_W'(nxt);
                        cur_frame = e.value;
                    end
                    else if (cfg_one_shot) begin
                        st = ST_DONE;
                        load_from(cur_pos);
                    end
                    else begin
                        st = ST_RESTARTED;
                        cur_pos = '0;
                        load_from(0);
                    end
                end
            end
            default: ;
        endcase
        return st;
    endfunction

    function automatic rsp_item_t advance_animation(cmd_item_t c);
        rsp_item_t   r;
        int unsigned p;
        case (c.action)
            ACT_TICK:
                last_st = frame_step();
            ACT_WRITE:
            begin
                if (c.sequence_number < NUM_SEQUENCES && c.position < SEQUENCE_DEPTH)
                    seq_store[c.sequence_number * SEQUENCE_DEPTH + c.position] =
                        '{is_end: c.entry_is_end, value: c.entry_value};
            end
            ACT_SELECT:
            begin
                if (c.sequence_number < NUM_SEQUENCES) begin
                    sel_seq = c.sequence_number;
                    cur_pos = '0;
                    if (cfg_mode == MODE_SEQUENCE)
                        load_from(0);
                end
            end
            ACT_SET_POS:
            begin
                if (cfg_mode == MODE_SEQUENCE || cfg_one_shot) begin
                    p = c.position;
                    if (p > SEQUENCE_DEPTH - 1)
                        p = SEQUENCE_DEPTH - 1;
                    cur_pos = POS_W'(p);
                    load_from(p);
                end
            end
            ACT_SET_FRAME:
            begin
                if (c.entry_value < cfg_frames)
                    cur_frame = c.entry_value;
            end
            default: ;
        endcase
        r.frame          = cur_frame;
        r.frame_position = cur_pos;
        r.status         = last_st;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (fail_total < MAX_REPORTS)
            $display("[%0t] mismatch on result %0d: %s", $time, rsp_total, msg);
        fail_total++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            reset_animation();
        end
        else begin
            if (cfg_write)
                apply_register(cfg_index, cfg_data);
            if (cmd_valid && cmd_ready) begin
                predicted = advance_animation(cmd);
                expected_frames_q = {expected_frames_q, predicted};
                cmd_total++;
            end
            if (rsp_valid && rsp_ready) begin
                if (expected_frames_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "result frame %0d position %0d status %0d with no command pending",
                        rsp.frame, rsp.frame_position, rsp.status));
                end
                else begin
                    want_rsp = expected_frames_q.pop_front();
                    if (rsp.frame !== want_rsp.frame)
                        report_mismatch($sformatf("frame %0d, expected %0d",
                            rsp.frame, want_rsp.frame));
                    if (rsp.frame_position !== want_rsp.frame_position)
                        report_mismatch($sformatf("position %0d, expected %0d",
                            rsp.frame_position, want_rsp.frame_position));
                    if (rsp.status !== want_rsp.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                            rsp.status, want_rsp.status));
                end
                rsp_total++;
            end
        end
        mismatches    <= fail_total;
        awaiting      <= expected_frames_q.size();
        commands_seen <= cmd_total;
        results_seen  <= rsp_total;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// frame animation sequencer testbench
// directed commands over each mode and table corner, then random commands
// and sequence loads under several register settings and stall patterns;
// the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;

    import fas_pkg::*;

    // action codes the block treats as no-ops
    localparam logic [2:0]  ACT_UNUSED_LO     = 3'd5;
    localparam logic [2:0]  ACT_UNUSED_HI     = 3'd7;

    localparam int unsigned PHASES            = 3;
    localparam int unsigned SETTINGS_PER_PASS = 5;
    localparam int unsigned ITEMS_PER_SETTING = 110;
    localparam int unsigned HOLDOFF_CYCLES    = 300;
    localparam int unsigned SETTLE_CYCLES     = 4;
    localparam int unsigned CYCLE_LIMIT       = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    cmd_item_t   cmd = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_item_t   rsp;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_MODE;
    logic [15:0] cfg_data = '0;

    int unsigned mismatch_count;
    int unsigned awaiting_count;
    int unsigned command_count;
    int unsigned result_count;

    // stall knobs, percent of cycles spent idle on each side
    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 46;
    logic        holdoff_req = 1'b0;
    logic        rsp_hold = 1'b0;

    // what the stimulus knows about the current setting
    mode_t       mode_now = MODE_SINGLE;
    int unsigned frames_now = 0;
    int unsigned settings_total = 0;
    int unsigned cycle_count = 0;

    frame_animation_sequencer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fas_frame_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatch_count),
        .awaiting      (awaiting_count),
        .commands_seen (command_count),
        .results_seen  (result_count)
    );

    // 12-unit clock, first rising edge at 6
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                cycle_count, awaiting_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: random back-pressure, forced low during the hold-off
    always @(posedge clk)
        rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);

    // one long hold-off on the result side; the sender keeps pushing so
    // the block fills up and has to drop cmd_ready
    initial begin
        wait (holdoff_req);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    function automatic cmd_item_t make_cmd(logic [2:0] a, int unsigned s, int unsigned p,
                                           int unsigned v, bit e);
        cmd_item_t c;
        c.action          = a;
        c.sequence_number = SEQ_W'(s);
        c.position        = POS_W'(p);
        c.entry_value     = 8'(v);
        c.entry_is_end    = e;
        return c;
    endfunction

    // random command: every field random, the action weighted toward ticks
    // and table writes so sequences actually play out
    function automatic cmd_item_t random_command();
        cmd_item_t   c;
        int unsigned pick;
        c = make_cmd(ACT_TICK, $urandom_range(NUM_SEQUENCES - 1),
                     $urandom_range(SEQUENCE_DEPTH - 1), $urandom_range(255),
                     $urandom_range(99) < 15);
        pick = $urandom_range(99);
        if (pick < 45)
            c.action = ACT_TICK;
        else if (pick < 65)
            c.action = ACT_WRITE;
        else if (pick < 75)
            c.action = ACT_SELECT;
        else if (pick < 84)
            c.action = ACT_SET_POS;
        else if (pick < 96) begin
            c.action = ACT_SET_FRAME;
            // half the time aim inside the frame bound so the write lands
            if ($urandom_range(1) && frames_now > 0)
                c.entry_value = 8'($urandom_range(frames_now - 1));
        end
        else
            c.action = 3'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
        return c;
    endfunction

    // offer one item, with random idle cycles in front of it
    task automatic send_item(cmd_item_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    // drop valid, wait for every expected result, then let the pipe settle
    task automatic drain_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (awaiting_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all four registers back to back while the block is idle
    task automatic configure(mode_t m, bit os, logic [15:0] spd, logic [8:0] frames);
        drain_results();
        cfg_write <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data  <= 16'(m);
        @(posedge clk);
        cfg_index <= CFG_ONE_SHOT;
        cfg_data  <= 16'(os);
        @(posedge clk);
        cfg_index <= CFG_SPEED;
        cfg_data  <= spd;
        @(posedge clk);
        cfg_index <= CFG_FRAME_COUNT;
        cfg_data  <= 16'(frames);
        @(posedge clk);
        cfg_write <= 1'b0;
        mode_now   = m;
        frames_now = frames;
        settings_total++;
    endtask

    // random setting, biased toward the stepping modes and short prescales
    task automatic configure_random();
        mode_t       m;
        logic [15:0] spd;
        logic [8:0]  frames;
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
            m = MODE_IDLE;
        else if (pick == 1)
            m = MODE_SINGLE;
        else if (pick < 5)
            m = MODE_COUNTED;
        else
            m = MODE_SEQUENCE;
        pick = $urandom_range(9);
        if (pick == 0)
            spd = 16'd0;
        else if (pick < 6)
            spd = 16'd1;
        else if (pick < 9)
            spd = 16'($urandom_range(3, 2));
        else
            spd = 16'($urandom_range(9, 4));
        pick = $urandom_range(7);
        if (pick == 0)
            frames = 9'd0;
        else if (pick == 1)
            frames = 9'd256;
        else if (pick == 2)
            frames = 9'd1;
        else if (pick < 6)
            frames = 9'($urandom_range(16, 2));
        else
            frames = 9'($urandom_range(255, 17));
        configure(m, $urandom_range(1), spd, frames);
    endtask

    // well-formed sequence: entries from position 0 up, an end mark after the
    // last one unless the whole row is used, then select it
    task automatic load_sequence_burst(output int unsigned sent);
        int unsigned seq;
        int unsigned len;
        seq  = $urandom_range(NUM_SEQUENCES - 1);
        len  = $urandom_range(SEQUENCE_DEPTH, 1);
        sent = 0;
        for (int unsigned p = 0; p <= len && p < SEQUENCE_DEPTH; p++) begin
            send_item(make_cmd(ACT_WRITE, seq, p, $urandom_range(255), p == len));
            sent++;
        end
        send_item(make_cmd(ACT_SELECT, seq, $urandom_range(SEQUENCE_DEPTH - 1),
                           $urandom_range(255), $urandom_range(1)));
        sent++;
    endtask

    initial begin
        int unsigned issued;
        int unsigned burst_items;
        int unsigned burst_pct;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: reset setting is single-frame, frame bound 0 ---
        // a command right after reset reports done; set frame is out of bound
        send_item(make_cmd(ACT_SET_FRAME, 0, 0, 0, 1'b0));
        send_item(make_cmd(ACT_TICK, 0, 0, 0, 1'b0));
        // sequence 0: ff, 00, 55 then an end mark
        send_item(make_cmd(ACT_WRITE, 0, 0, 8'hFF, 1'b0));
        send_item(make_cmd(ACT_WRITE, 0, 1, 8'h00, 1'b0));
        send_item(make_cmd(ACT_WRITE, 0, 2, 8'h55, 1'b0));
        send_item(make_cmd(ACT_WRITE, 0, 3, 8'hAA, 1'b1));
        // last row, last slot
        send_item(make_cmd(ACT_WRITE, 7, 15, 8'h80, 1'b0));
        // set position is refused outside sequence mode without one-shot
        send_item(make_cmd(ACT_SET_POS, 0, 2, 0, 1'b0));

        // sequence mode, restarting, speed 0 acts as 1, widest frame bound
        configure(MODE_SEQUENCE, 1'b0, 16'd0, 9'd256);
        send_item(make_cmd(ACT_SELECT, 0, 0, 0, 1'b0));
        repeat (3) send_item(make_cmd(ACT_TICK, 0, 0, 0, 1'b0));
        // jump to an end-mark slot, then step off the end of the table
        send_item(make_cmd(ACT_SET_POS, 0, 15, 0, 1'b0));
        send_item(make_cmd(ACT_TICK, 0, 0, 0, 1'b0));
        // empty sequence keeps the current frame on select and on restart
        send_item(make_cmd(ACT_SELECT, 5, 0, 0, 1'b0));
        send_item(make_cmd(ACT_TICK, 0, 0, 0, 1'b0));
        send_item(make_cmd(ACT_SELECT, 7, 0, 0, 1'b0));
        send_item(make_cmd(ACT_SET_POS, 0, 15, 0, 1'b0));
        send_item(make_cmd(ACT_TICK, 0, 0, 0, 1'b0));
        send_item(make_cmd(ACT_SET_FRAME, 0, 0, 255, 1'b0));
        send_item(make_cmd(ACT_UNUSED_HI, 7, 15, 255, 1'b1));
        send_item(make_cmd(ACT_UNUSED_LO, 0, 0, 0, 1'b0));

        // one-shot sequence holds its last frame and reports done
        configure(MODE_SEQUENCE, 1'b1, 16'd1, 9'd16);
        send_item(make_cmd(ACT_SELECT, 0, 0, 0, 1'b0));
        repeat (3) send_item(make_cmd(ACT_TICK, 0, 0, 0, 1'b0));

        // counted mode wraps when the next frame passes 255
        configure(MODE_COUNTED, 1'b1, 16'd1, 9'd256);
        send_item(make_cmd(ACT_SET_FRAME, 0, 0, 254, 1'b0));
        repeat (2) send_item(make_cmd(ACT_TICK, 0, 0, 0, 1'b0));
        // one-shot lets set position act in counted mode
        send_item(make_cmd(ACT_SET_POS, 0, 3, 0, 1'b0));

        // zero frame bound keeps frame 0 and reports a restart
        configure(MODE_COUNTED, 1'b0, 16'd2, 9'd0);
        repeat (2) send_item(make_cmd(ACT_TICK, 0, 0, 0, 1'b0));

        // idle mode: ticks change only the status (running), slowest prescale
        configure(MODE_IDLE, 1'b0, 16'hFFFF, 9'd1);
        send_item(make_cmd(ACT_TICK, 0, 0, 0, 1'b0));

        // --- random: three stall patterns, several settings each ---
        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:
                begin
                    send_idle_pct <= 27;
                    recv_idle_pct <= 46;
                end
                1:
                begin
                    send_idle_pct <= 46;
                    recv_idle_pct <= 27;
                end
                default:
                begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (int unsigned k = 0; k < SETTINGS_PER_PASS; k++) begin
                configure_random();
                // no-stall pass opens with the long result hold-off
                if (phase == PHASES - 1 && k == 0)
                    holdoff_req <= 1'b1;
                burst_pct = (mode_now == MODE_SEQUENCE) ? 6 : 2;
                issued = 0;
                while (issued < ITEMS_PER_SETTING) begin
                    if ($urandom_range(99) < burst_pct) begin
                        load_sequence_burst(burst_items);
                        issued += burst_items;
                    end
                    else begin
                        send_item(random_command());
                        issued++;
                    end
                end
            end
        end

        drain_results();
        $display("ran %0d commands, %0d results checked over %0d register settings,",
            command_count, result_count, settings_total);
        $display("with both sides stalling and one %0d-cycle result hold-off",
            HOLDOFF_CYCLES);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/fas_pkg.sv
design/frame_animation_sequencer_unit.sv
tb/sv/fas_frame_checker.sv
tb/sv/tb_top.sv
